/* src/lpsu_pkg.sv */
// ----------------------------------------------------------------------------
// lpsu_pkg
// shared types and codes for the line pixel stepper
// ----------------------------------------------------------------------------
package lpsu_pkg;

  // operation codes on the input channel
  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // per-item command flags passed from front to back
  typedef struct packed {
    logic is_start;   // item begins a new line
    logic steep;      // major axis is y
    logic minor_neg;  // minor coordinate steps down
  } lpsu_ctrl_t;

  localparam int CTRL_W = $bits(lpsu_ctrl_t);

endpackage

/* src/line_pixel_stepper_unit.sv */
// ----------------------------------------------------------------------------
// line_pixel_stepper_unit
// bresenham line generator for all octants; unless stalled, one pixel per clock
// ----------------------------------------------------------------------------
// A start item (operation 0) carries two signed endpoints; the unit picks the
// major axis (y on a tie or for a zero-length line), orders the endpoints so
// the major coordinate increases and returns the first pixel. Each advance
// item (operation 1) returns the next pixel; the end point is always included
// and carries last_pixel. An advance with no line in progress returns nothing,
// and a start during a line drops the old one. The classifier takes one item
// per cycle into a two-entry command queue while the queue has room, and the
// stepper retires one queued item per cycle while the output is not stalled,
// its single error-term update setting that pace. An item goes into the queue
// and then to the stepper's registered pixel output; the queue lets the input
// keep flowing for two items while the output is stalled.
module line_pixel_stepper_unit import lpsu_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         operation,
  input  logic signed [COORD_BITS-1:0] x_start,
  input  logic signed [COORD_BITS-1:0] y_start,
  input  logic signed [COORD_BITS-1:0] x_end,
  input  logic signed [COORD_BITS-1:0] y_end,
  // output channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] pixel_x,
  output logic signed [COORD_BITS-1:0] pixel_y,
  output logic                         last_pixel
);

  localparam int C      = COORD_BITS;
  localparam int E      = COORD_BITS + 3;
  localparam int Q_W    = CTRL_W + 5 * C + E;
  localparam int Q_DEPTH = 2;

  // classifier outputs
  lpsu_ctrl_t          f_ctrl;
  logic        [C-1:0] f_maj_pos;
  logic        [C-1:0] f_min_pos;
  logic        [C-1:0] f_maj_stop;
  logic        [C-1:0] f_maj_delta;
  logic        [C-1:0] f_min_delta;
  logic signed [E-1:0] f_err_init;

  // queue head
  lpsu_ctrl_t          q_ctrl;
  logic        [C-1:0] q_maj_pos;
  logic        [C-1:0] q_min_pos;
  logic        [C-1:0] q_maj_stop;
  logic        [C-1:0] q_maj_delta;
  logic        [C-1:0] q_min_delta;
  logic signed [E-1:0] q_err_init;

  logic [Q_W-1:0] q_push_data;
  logic [Q_W-1:0] q_head_data;
  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_empty;
  logic           line_active;

  lpsu_front #(.COORD_BITS(COORD_BITS)) u_front (
    .operation (operation),
    .x_start   (x_start),
    .y_start   (y_start),
    .x_end     (x_end),
    .y_end     (y_end),
    .ctrl      (f_ctrl),
    .maj_pos   (f_maj_pos),
    .min_pos   (f_min_pos),
    .maj_stop  (f_maj_stop),
    .maj_delta (f_maj_delta),
    .min_delta (f_min_delta),
    .err_init  (f_err_init)
  );

  // input transfer lands straight in the queue
  assign in_stall    = q_full;
  assign q_push      = in_valid && !q_full;
  assign q_push_data = {f_ctrl, f_maj_pos, f_min_pos, f_maj_stop,
                        f_maj_delta, f_min_delta, f_err_init};

  lpsu_fifo #(.DATA_W(Q_W), .DEPTH(Q_DEPTH)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .head_data (q_head_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  assign {q_ctrl, q_maj_pos, q_min_pos, q_maj_stop,
          q_maj_delta, q_min_delta, q_err_init} = q_head_data;

  lpsu_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (!q_empty),
    .cmd_take      (q_pop),
    .ctrl          (q_ctrl),
    .cmd_maj_pos   (q_maj_pos),
    .cmd_min_pos   (q_min_pos),
    .cmd_maj_stop  (q_maj_stop),
    .cmd_maj_delta (q_maj_delta),
    .cmd_min_delta (q_min_delta),
    .cmd_err_init  (q_err_init),
    .line_active   (line_active),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .last_pixel    (last_pixel)
  );

  // queue occupancy flags never both set
  assert property (@(posedge clk) disable iff (rst) !(q_full && q_empty))
    else $error("command queue reports full and empty at once");

  // a start always yields a pixel on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_ctrl.is_start) |=> out_valid)
    else $error("start command produced no pixel");

  // an advance with no line in progress yields nothing
  assert property (@(posedge clk) disable iff (rst)
    (q_pop && !q_ctrl.is_start && !line_active) |=> !out_valid)
    else $error("idle advance produced a pixel");

  // pushing is only possible while the queue has room, so a full queue stays full until it pops
  assert property (@(posedge clk) disable iff (rst)
    (q_full && !q_pop) |=> q_full)
    else $error("command queue lost an entry");

endmodule

/* src/lpsu_front.sv */
// ----------------------------------------------------------------------------
// lpsu_front
// classifies an input item: picks the major axis and orders the endpoints
// ----------------------------------------------------------------------------
module lpsu_front import lpsu_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                         operation,
  input  logic signed [COORD_BITS-1:0] x_start,
  input  logic signed [COORD_BITS-1:0] y_start,
  input  logic signed [COORD_BITS-1:0] x_end,
  input  logic signed [COORD_BITS-1:0] y_end,
  output lpsu_ctrl_t                   ctrl,
  output logic        [COORD_BITS-1:0] maj_pos,
  output logic        [COORD_BITS-1:0] min_pos,
  output logic        [COORD_BITS-1:0] maj_stop,
  output logic        [COORD_BITS-1:0] maj_delta,
  output logic        [COORD_BITS-1:0] min_delta,
  output logic signed [COORD_BITS+2:0] err_init
);

  localparam int C = COORD_BITS;

  logic signed [C:0]   dx;
  logic signed [C:0]   dy;
  logic        [C:0]   dx_neg;
  logic        [C:0]   dy_neg;
  logic        [C-1:0] adx;
  logic        [C-1:0] ady;
  logic                steep;
  logic                swap;
  logic signed [C-1:0] a0;
  logic signed [C-1:0] a1;
  logic signed [C-1:0] b0;
  logic signed [C-1:0] b1;
  logic signed [C-1:0] min_first;
  logic signed [C-1:0] min_last;

  // absolute deltas, one bit wider so they never overflow
  assign dx     = {x_end[C-1], x_end} - {x_start[C-1], x_start};
  assign dy     = {y_end[C-1], y_end} - {y_start[C-1], y_start};
  assign dx_neg = -dx;
  assign dy_neg = -dy;
  assign adx    = dx[C] ? dx_neg[C-1:0] : dx[C-1:0];
  assign ady    = dy[C] ? dy_neg[C-1:0] : dy[C-1:0];

  // ties and zero-length lines go along y
  assign steep = !(ady < adx);

  assign a0 = steep ? y_start : x_start;
  assign b0 = steep ? x_start : y_start;
  assign a1 = steep ? y_end   : x_end;
  assign b1 = steep ? x_end   : y_end;

  // major coordinate must increase
  assign swap      = a0 > a1;
  assign min_first = swap ? b1 : b0;
  assign min_last  = swap ? b0 : b1;

  assign maj_pos   = swap ? a1 : a0;
  assign min_pos   = min_first;
  assign maj_stop  = swap ? a0 : a1;
  assign maj_delta = steep ? ady : adx;
  assign min_delta = steep ? adx : ady;
  assign err_init  = $signed({2'b00, min_delta, 1'b0}) - $signed({3'b000, maj_delta});

  assign ctrl.is_start  = (operation == OP_START);
  assign ctrl.steep     = steep;
  assign ctrl.minor_neg = min_last < min_first;

endmodule

/* src/lpsu_fifo.sv */
// ----------------------------------------------------------------------------
// lpsu_fifo
// short command queue between the classifier and the stepper
// ----------------------------------------------------------------------------
module lpsu_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] head_data,
  output logic              full,
  output logic              empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign head_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* src/lpsu_back.sv */
// ----------------------------------------------------------------------------
// lpsu_back
// bresenham stepper with registered pixel output
// ----------------------------------------------------------------------------
module lpsu_back import lpsu_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  output logic                         cmd_take,
  input  lpsu_ctrl_t                   ctrl,
  input  logic        [COORD_BITS-1:0] cmd_maj_pos,
  input  logic        [COORD_BITS-1:0] cmd_min_pos,
  input  logic        [COORD_BITS-1:0] cmd_maj_stop,
  input  logic        [COORD_BITS-1:0] cmd_maj_delta,
  input  logic        [COORD_BITS-1:0] cmd_min_delta,
  input  logic signed [COORD_BITS+2:0] cmd_err_init,
  output logic                         line_active,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] pixel_x,
  output logic signed [COORD_BITS-1:0] pixel_y,
  output logic                         last_pixel
);

  localparam int C = COORD_BITS;
  localparam int E = COORD_BITS + 3;

  logic                steep_line;
  logic                minor_dir_negative;
  logic        [C-1:0] major_pos;
  logic        [C-1:0] minor_pos;
  logic        [C-1:0] major_stop;
  logic        [C-1:0] major_delta;
  logic        [C-1:0] minor_delta;
  logic signed [E-1:0] error_term;

  logic                out_free;
  logic                emit;
  logic                cur_steep;
  logic                cur_neg;
  logic        [C-1:0] cur_maj;
  logic        [C-1:0] cur_min;
  logic        [C-1:0] cur_stop;
  logic        [C-1:0] cur_majd;
  logic        [C-1:0] cur_mind;
  logic signed [E-1:0] cur_err;
  logic                at_end;
  logic        [C:0]   delta_diff;
  logic signed [E-1:0] err_up;
  logic signed [E-1:0] err_flat;
  logic signed [E-1:0] error_term_next;
  logic        [C-1:0] minor_pos_next;

  assign out_free = !out_valid || !out_stall;
  assign cmd_take = cmd_valid && out_free;
  // an advance with no line in progress is dropped
  assign emit     = cmd_take && (ctrl.is_start || line_active);

  assign cur_steep = ctrl.is_start ? ctrl.steep     : steep_line;
  assign cur_neg   = ctrl.is_start ? ctrl.minor_neg : minor_dir_negative;
  assign cur_maj   = ctrl.is_start ? cmd_maj_pos    : major_pos;
  assign cur_min   = ctrl.is_start ? cmd_min_pos    : minor_pos;
  assign cur_stop  = ctrl.is_start ? cmd_maj_stop   : major_stop;
  assign cur_majd  = ctrl.is_start ? cmd_maj_delta  : major_delta;
  assign cur_mind  = ctrl.is_start ? cmd_min_delta  : minor_delta;
  assign cur_err   = ctrl.is_start ? cmd_err_init   : error_term;

  assign at_end = $signed(cur_maj) >= $signed(cur_stop);

  assign delta_diff = {1'b0, cur_mind} - {1'b0, cur_majd};
  assign err_up     = cur_err + $signed({delta_diff[C], delta_diff, 1'b0});
  assign err_flat   = cur_err + $signed({2'b00, cur_mind, 1'b0});

  always_comb begin
    minor_pos_next  = cur_min;
    error_term_next = err_flat;
    if (cur_err > 0) begin
      minor_pos_next  = cur_neg ? cur_min - 1'b1 : cur_min + 1'b1;
      error_term_next = err_up;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      steep_line         <= cur_steep;
      minor_dir_negative <= cur_neg;
      major_stop         <= cur_stop;
      major_delta        <= cur_majd;
      minor_delta        <= cur_mind;
      major_pos          <= cur_maj + 1'b1;
      minor_pos          <= minor_pos_next;
      error_term         <= error_term_next;
      pixel_x            <= cur_steep ? cur_min : cur_maj;
      pixel_y            <= cur_steep ? cur_maj : cur_min;
      last_pixel         <= at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (emit) begin
        line_active <= !at_end;
        out_valid   <= 1'b1;
      end else if (!out_stall) begin
        out_valid   <= 1'b0;
      end
    end
  end

endmodule
